/* rtl/psts_pkg.sv */
// Shared types, codes and constants of the pixel signal and track store.
`default_nettype none

package psts_pkg;

  // Default geometry of the pixel store.
  localparam int MAX_ROWS_DEF    = 16;
  localparam int MAX_COLS_DEF    = 16;
  localparam int MAX_TIMES_DEF   = 32;
  localparam int TRACK_SLOTS_DEF = 3;

  // Field widths fixed by the stream format.
  localparam int CMD_W    = 3;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int TBIN_W   = 5;
  localparam int SLOT_W   = 2;
  localparam int SIGNAL_W = 32;
  localparam int TRACK_W  = 21;

  // Configuration register widths.
  localparam int ROWS_CFG_W  = 5;
  localparam int COLS_CFG_W  = 5;
  localparam int TIMES_CFG_W = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // A free track slot holds all ones.
  localparam logic signed [TRACK_W-1:0] EMPTY_TRACK = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_TIMES = 2'd2
  } psts_reg_t;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_SIGNAL  = 3'd0,
    CMD_SET_SIGNAL  = 3'd1,
    CMD_ADD_TRACK   = 3'd2,
    CMD_SET_TRACK   = 3'd3,
    CMD_READ_SIGNAL = 3'd4,
    CMD_READ_TRACK  = 3'd5
  } psts_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_ADDR,
    S_READ,
    S_DONE
  } psts_state_t;

  // One result word.
  typedef struct packed {
    logic        [0:0]          in_range;
    logic        [0:0]          track_stored;
    logic signed [TRACK_W-1:0]  track_out;
    logic signed [SIGNAL_W-1:0] signal_out;
  } psts_result_t;

endpackage

`default_nettype wire

/* rtl/psts_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module psts_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8192,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/psts_addr.sv */
// Range check and two-stage address computation for a pixel coordinate.
`default_nettype none

module psts_addr #(
  parameter  int MAX_ROWS  = psts_pkg::MAX_ROWS_DEF,
  parameter  int MAX_COLS  = psts_pkg::MAX_COLS_DEF,
  parameter  int MAX_TIMES = psts_pkg::MAX_TIMES_DEF,
  localparam int DEPTH     = MAX_ROWS * MAX_COLS * MAX_TIMES,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk,
  input  wire logic [psts_pkg::ROWS_CFG_W-1:0]    rows_in_use,
  input  wire logic [psts_pkg::COLS_CFG_W-1:0]    cols_in_use,
  input  wire logic [psts_pkg::TIMES_CFG_W-1:0]   times_in_use,
  input  wire logic [psts_pkg::ROW_W-1:0]         row,
  input  wire logic [psts_pkg::COL_W-1:0]         col,
  input  wire logic [psts_pkg::TBIN_W-1:0]        time_bin,
  output logic                                    ok,
  output logic      [AW-1:0]                      addr
);

  localparam int RC_W  = psts_pkg::ROW_W + psts_pkg::COLS_CFG_W + 1;
  localparam int IDX_W = RC_W + psts_pkg::TIMES_CFG_W + 1;

  logic [psts_pkg::ROWS_CFG_W-1:0]  eff_rows;
  logic [psts_pkg::COLS_CFG_W-1:0]  eff_cols;
  logic [psts_pkg::TIMES_CFG_W-1:0] eff_times;
  logic                             ok_comb;
  logic [RC_W-1:0]                  rc_comb;
  logic [RC_W-1:0]                  rc_s1;
  logic [psts_pkg::TBIN_W-1:0]      tb_s1;
  logic [psts_pkg::TIMES_CFG_W-1:0] et_s1;
  logic                             ok_s1;
  logic [IDX_W-1:0]                 idx_comb;

  // Sizes above the built-in maximum are taken as the maximum.
  assign eff_rows  = (32'(rows_in_use) > MAX_ROWS) ?
                     psts_pkg::ROWS_CFG_W'(MAX_ROWS) : rows_in_use;
  assign eff_cols  = (32'(cols_in_use) > MAX_COLS) ?
                     psts_pkg::COLS_CFG_W'(MAX_COLS) : cols_in_use;
  assign eff_times = (32'(times_in_use) > MAX_TIMES) ?
                     psts_pkg::TIMES_CFG_W'(MAX_TIMES) : times_in_use;

  // The pixel is in range when every coordinate is below its size.
  assign ok_comb = ({1'b0, row} < eff_rows) && ({1'b0, col} < eff_cols) &&
                   ({1'b0, time_bin} < eff_times);

  // Stage one: row * cols + col.
  assign rc_comb = RC_W'(row) * RC_W'(eff_cols) + RC_W'(col);

  always_ff @(posedge clk) begin
    rc_s1 <= rc_comb;
    tb_s1 <= time_bin;
    et_s1 <= eff_times;
    ok_s1 <= ok_comb;
  end

  // Stage two: (row * cols + col) * times + time_bin. In range it stays below the depth.
  assign idx_comb = IDX_W'(rc_s1) * IDX_W'(et_s1) + IDX_W'(tb_s1);

  always_ff @(posedge clk) begin
    addr <= AW'(idx_comb);
    ok   <= ok_s1;
  end

endmodule

`default_nettype wire

/* rtl/psts_update.sv */
// Read-modify-write datapath: new signal and track words and the result word.
`default_nettype none

module psts_update #(
  parameter  int TRACK_SLOTS = psts_pkg::TRACK_SLOTS_DEF,
  localparam int TRK_ROW_W   = TRACK_SLOTS * psts_pkg::TRACK_W
) (
  input  wire logic [psts_pkg::CMD_W-1:0]           command,
  input  wire logic [psts_pkg::SLOT_W-1:0]          slot,
  input  wire logic signed [psts_pkg::SIGNAL_W-1:0] signal_in,
  input  wire logic signed [psts_pkg::TRACK_W-1:0]  track_in,
  input  wire logic                                 ok,
  input  wire logic signed [psts_pkg::SIGNAL_W-1:0] sig_rd,
  input  wire logic [TRK_ROW_W-1:0]                 trk_rd,
  output logic                                      sig_we,
  output logic signed [psts_pkg::SIGNAL_W-1:0]      sig_wdata,
  output logic                                      trk_we,
  output logic [TRK_ROW_W-1:0]                      trk_wdata,
  output psts_pkg::psts_result_t                    result
);

  localparam int SW = psts_pkg::SIGNAL_W;
  localparam int TW = psts_pkg::TRACK_W;

  logic signed [TW-1:0] slots     [TRACK_SLOTS];
  logic signed [TW-1:0] slots_new [TRACK_SLOTS];
  logic signed [SW:0]   sum;
  logic signed [SW-1:0] sat_sum;
  logic                 add_done;
  logic                 add_write;
  logic                 slot_ok;

  // Split the stored track row into its slots.
  always_comb begin
    for (int s = 0; s < TRACK_SLOTS; s++) begin
      slots[s] = trk_rd[s*TW +: TW];
    end
  end

  // Saturating accumulate.
  assign sum     = {sig_rd[SW-1], sig_rd} + {signal_in[SW-1], signal_in};
  assign sat_sum = (sum[SW] != sum[SW-1]) ?
                   (sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}}) :
                   sum[SW-1:0];

  assign slot_ok = 32'(slot) < TRACK_SLOTS;

  // Command decode, slot search and result word.
  always_comb begin
    sig_we              = 1'b0;
    sig_wdata           = signal_in;
    trk_we              = 1'b0;
    add_done            = 1'b0;
    add_write           = 1'b0;
    result.signal_out   = '0;
    result.track_out    = psts_pkg::EMPTY_TRACK;
    result.track_stored = 1'b0;
    result.in_range     = ok;
    for (int s = 0; s < TRACK_SLOTS; s++) begin
      slots_new[s] = slots[s];
    end
    unique case (command)
      psts_pkg::CMD_ADD_SIGNAL: begin
        sig_we    = ok;
        sig_wdata = sat_sum;
      end
      psts_pkg::CMD_SET_SIGNAL: begin
        sig_we = ok;
      end
      psts_pkg::CMD_ADD_TRACK: begin
        // The first slot that matches or is free ends the search; a free slot takes the track.
        for (int s = 0; s < TRACK_SLOTS; s++) begin
          if (!add_done) begin
            if (slots[s] == track_in) begin
              add_done = 1'b1;
            end else if (slots[s] == psts_pkg::EMPTY_TRACK) begin
              add_done     = 1'b1;
              add_write    = 1'b1;
              slots_new[s] = track_in;
            end
          end
        end
        trk_we              = ok && add_write;
        result.track_stored = !ok || add_done;
      end
      psts_pkg::CMD_SET_TRACK: begin
        for (int s = 0; s < TRACK_SLOTS; s++) begin
          if (32'(slot) == s) begin
            slots_new[s] = track_in;
          end
        end
        trk_we = ok && slot_ok;
      end
      psts_pkg::CMD_READ_SIGNAL: begin
        if (ok) begin
          result.signal_out = sig_rd;
        end
      end
      psts_pkg::CMD_READ_TRACK: begin
        if (ok) begin
          for (int s = 0; s < TRACK_SLOTS; s++) begin
            if (32'(slot) == s) begin
              result.track_out = slots[s];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Reassemble the track row.
  always_comb begin
    for (int s = 0; s < TRACK_SLOTS; s++) begin
      trk_wdata[s*TW +: TW] = slots_new[s];
    end
  end

endmodule

`default_nettype wire

/* rtl/pixel_signal_track_store_core.sv */
// Top level of the pixel signal and track store.
//
// Commands arrive as words on the s_axis channel; every accepted word gives
// exactly one result word on the m_axis channel. The store keeps, for each
// (row, col, time_bin) pixel, a Q23.8 signal and a set of track slots in two
// block RAMs with a registered read port.
// Each word goes through a fixed sequence: capture, row/column multiply,
// time multiply, RAM read, then modify and write back. The result word is
// registered at write-back, and s_axis_tready is high again in the same
// cycle as the result turns valid. As the read-modify-write on the single
// RAM pair is serial, no word is taken until the last one is written back.
// Configuration writes on the cfg channel are always ready and must only be
// made while no word is in flight.
// After reset the block sweeps both RAMs, one pixel a cycle, to zero signals
// and free slots: s_axis_tready is low until all MAX_ROWS*MAX_COLS*MAX_TIMES
// pixels (8192 with default sizes) are cleared. When the receiver stalls, the
// result is held in the output register; one more word is accepted and worked
// up to its write-back, where it waits until the output register is free.
`default_nettype none

module pixel_signal_track_store_core #(
  parameter int MAX_ROWS    = psts_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = psts_pkg::MAX_COLS_DEF,
  parameter int MAX_TIMES   = psts_pkg::MAX_TIMES_DEF,
  parameter int TRACK_SLOTS = psts_pkg::TRACK_SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Command words.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // command[2:0], row[6:3], col[10:7], time_bin[15:11], slot[17:16],
  // signal_in[49:18], track_in[70:50], zero[71]
  input  wire logic [71:0]                         s_axis_tdata,
  // Result words.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // signal_out[31:0], track_out[52:32], track_stored[53], in_range[54], zero[55]
  output logic      [55:0]                         m_axis_tdata,
  // Configuration writes.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [psts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [psts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH     = MAX_ROWS * MAX_COLS * MAX_TIMES;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW        = psts_pkg::SIGNAL_W;
  localparam int TW        = psts_pkg::TRACK_W;
  localparam int TRK_ROW_W = TRACK_SLOTS * TW;

  psts_pkg::psts_state_t              state;
  psts_pkg::psts_state_t              state_next;
  logic [AW-1:0]                      clr_addr;
  logic                               clr_last;
  logic                               accept;
  logic                               finish;
  logic                               rd_en;

  logic [psts_pkg::ROWS_CFG_W-1:0]    rows_in_use;
  logic [psts_pkg::COLS_CFG_W-1:0]    cols_in_use;
  logic [psts_pkg::TIMES_CFG_W-1:0]   times_in_use;

  logic [psts_pkg::CMD_W-1:0]         command;
  logic [psts_pkg::ROW_W-1:0]         row;
  logic [psts_pkg::COL_W-1:0]         col;
  logic [psts_pkg::TBIN_W-1:0]        time_bin;
  logic [psts_pkg::SLOT_W-1:0]        slot;
  logic signed [SW-1:0]               signal_in;
  logic signed [TW-1:0]               track_in;

  logic                               pix_ok;
  logic [AW-1:0]                      pix_addr;

  logic signed [SW-1:0]               sig_rd;
  logic [TRK_ROW_W-1:0]               trk_rd;
  logic                               upd_sig_we;
  logic signed [SW-1:0]               upd_sig_wdata;
  logic                               upd_trk_we;
  logic [TRK_ROW_W-1:0]               upd_trk_wdata;
  psts_pkg::psts_result_t             upd_result;

  logic                               sig_we;
  logic [SW-1:0]                      sig_wdata;
  logic                               trk_we;
  logic [TRK_ROW_W-1:0]               trk_wdata;
  logic [AW-1:0]                      wr_addr;

  psts_pkg::psts_result_t             out_word;

  assign cfg_ready = 1'b1;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= psts_pkg::ROWS_CFG_W'(16);
      cols_in_use  <= psts_pkg::COLS_CFG_W'(16);
      times_in_use <= psts_pkg::TIMES_CFG_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psts_pkg::REG_ROWS:  rows_in_use  <= cfg_data[psts_pkg::ROWS_CFG_W-1:0];
        psts_pkg::REG_COLS:  cols_in_use  <= cfg_data[psts_pkg::COLS_CFG_W-1:0];
        psts_pkg::REG_TIMES: times_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state register and clear sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= psts_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == psts_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign clr_last = (clr_addr == AW'(DEPTH - 1));

  // Next state and sequencer outputs.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    finish        = 1'b0;
    rd_en         = 1'b0;
    unique case (state)
      psts_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_next = psts_pkg::S_IDLE;
        end
      end
      psts_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          accept     = 1'b1;
          state_next = psts_pkg::S_MAP;
        end
      end
      psts_pkg::S_MAP: begin
        state_next = psts_pkg::S_ADDR;
      end
      psts_pkg::S_ADDR: begin
        state_next = psts_pkg::S_READ;
      end
      psts_pkg::S_READ: begin
        rd_en      = 1'b1;
        state_next = psts_pkg::S_DONE;
      end
      psts_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          finish     = 1'b1;
          state_next = psts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psts_pkg::S_IDLE;
      end
    endcase
  end

  // Capture the command word.
  always_ff @(posedge clk) begin
    if (accept) begin
      command   <= s_axis_tdata[2:0];
      row       <= s_axis_tdata[6:3];
      col       <= s_axis_tdata[10:7];
      time_bin  <= s_axis_tdata[15:11];
      slot      <= s_axis_tdata[17:16];
      signal_in <= s_axis_tdata[49:18];
      track_in  <= s_axis_tdata[70:50];
    end
  end

  psts_addr #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .MAX_TIMES    (MAX_TIMES)
  ) u_addr (
    .clk          (clk),
    .rows_in_use  (rows_in_use),
    .cols_in_use  (cols_in_use),
    .times_in_use (times_in_use),
    .row          (row),
    .col          (col),
    .time_bin     (time_bin),
    .ok           (pix_ok),
    .addr         (pix_addr)
  );

  psts_update #(
    .TRACK_SLOTS (TRACK_SLOTS)
  ) u_update (
    .command     (command),
    .slot        (slot),
    .signal_in   (signal_in),
    .track_in    (track_in),
    .ok          (pix_ok),
    .sig_rd      (sig_rd),
    .trk_rd      (trk_rd),
    .sig_we      (upd_sig_we),
    .sig_wdata   (upd_sig_wdata),
    .trk_we      (upd_trk_we),
    .trk_wdata   (upd_trk_wdata),
    .result      (upd_result)
  );

  // Write port: the clear sweep after reset, then write-back of one word.
  assign wr_addr   = (state == psts_pkg::S_CLEAR) ? clr_addr : pix_addr;
  assign sig_we    = (state == psts_pkg::S_CLEAR) || (finish && upd_sig_we);
  assign trk_we    = (state == psts_pkg::S_CLEAR) || (finish && upd_trk_we);
  assign sig_wdata = (state == psts_pkg::S_CLEAR) ? '0 : upd_sig_wdata;
  assign trk_wdata = (state == psts_pkg::S_CLEAR) ? '1 : upd_trk_wdata;

  psts_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_signal_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (wr_addr),
    .wdata (sig_wdata),
    .re    (rd_en),
    .raddr (pix_addr),
    .rdata (sig_rd)
  );

  psts_ram #(
    .WIDTH (TRK_ROW_W),
    .DEPTH (DEPTH)
  ) u_track_ram (
    .clk   (clk),
    .we    (trk_we),
    .waddr (wr_addr),
    .wdata (trk_wdata),
    .re    (rd_en),
    .raddr (pix_addr),
    .rdata (trk_rd)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_word <= upd_result;
    end
  end

  assign m_axis_tdata = {1'b0, out_word};

`ifndef NO_ASSERTIONS
  // No command word is taken while the RAMs are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == psts_pkg::S_CLEAR) |-> !s_axis_tready)
    else $error("command word accepted during clear sweep");

  // A new result word appears only after a write-back step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == psts_pkg::S_DONE))
    else $error("result word without write-back");

  // Outside the clear sweep the RAMs are written only at write-back.
  a_write_at_done: assert property (@(posedge clk) disable iff (rst)
    (sig_we || trk_we) |-> (state == psts_pkg::S_CLEAR || state == psts_pkg::S_DONE))
    else $error("RAM written outside clear or write-back");

  // An out-of-range pixel reads as zero signal and an empty slot.
  a_out_of_range_defaults: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[54]) |->
      (m_axis_tdata[31:0] == '0 && m_axis_tdata[52:32] == psts_pkg::EMPTY_TRACK))
    else $error("out-of-range pixel returned stored data");
`endif

endmodule

`default_nettype wire
